FILE: src/char_lcd_parallel_write_sequencer_unit_macros.svh
// Assertion helpers for the LCD write sequencer checkers.
`ifndef CHAR_LCD_PARALLEL_WRITE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_PARALLEL_WRITE_SEQUENCER_UNIT_MACROS_SVH

`define CLPWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CLPWS_ASSERT_SAME(lbl, ante, cons, msg) \
  `CLPWS_ASSERT(lbl, ante |-> cons, msg)

`define CLPWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CLPWS_ASSERT(lbl, ante |=> cons, msg)

`endif

FILE: src/clpws_pkg.sv
package clpws_pkg;

  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_INSTR,
    CMD_CHAR,
    CMD_SLOW_CHAR,
    CMD_CURSOR,
    CMD_CLEAR,
    CMD_HOME,
    CMD_WAKE
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INSTR_SETUP,
    REG_CHAR_SETUP,
    REG_ENABLE,
    REG_LONG_WAIT,
    REG_SHORT_WAIT
  } reg_idx_e;

  typedef enum logic [1:0] {
    PW_NONE,
    PW_LONG,
    PW_SHORT
  } post_e;

  localparam logic [CfgW-1:0] InstrSetupRst = CfgW'(2000);
  localparam logic [CfgW-1:0] CharSetupRst  = CfgW'(1000);
  localparam logic [CfgW-1:0] EnableRst     = CfgW'(1000);
  localparam logic [CfgW-1:0] LongWaitRst   = CfgW'(100000);
  localparam logic [CfgW-1:0] ShortWaitRst  = CfgW'(10000);

  localparam logic [7:0] LcdWake       = 8'h30;
  localparam logic [7:0] LcdFuncSet    = 8'h38;
  localparam logic [7:0] LcdShift      = 8'h10;
  localparam logic [7:0] LcdDisplayOn  = 8'h0F;
  localparam logic [7:0] LcdEntryMode  = 8'h06;
  localparam logic [7:0] LcdClear      = 8'h01;
  localparam logic [7:0] LcdHome       = 8'h02;
  localparam logic [7:0] LcdDdramBase  = 8'h80;
  localparam logic [7:0] LcdLineStride = 8'h40;

  localparam logic [2:0] WakeLastStep = 3'd6;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       line_select;
    logic [5:0] column;
  } cmd_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic       reg_sel;
    logic       read_write;
    logic       enable_pin;
    logic       busy_res;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic [CfgW-1:0] instr_setup;
    logic [CfgW-1:0] char_setup;
    logic [CfgW-1:0] enable;
    logic [CfgW-1:0] long_wait;
    logic [CfgW-1:0] short_wait;
  } cfg_t;

  function automatic logic [7:0] wake_byte(input logic [2:0] step);
    case (step)
      3'd0, 3'd1, 3'd2: return LcdWake;
      3'd3:             return LcdFuncSet;
      3'd4:             return LcdShift;
      3'd5:             return LcdDisplayOn;
      default:          return LcdEntryMode;
    endcase
  endfunction

  function automatic post_e wake_post(input logic [2:0] step);
    case (step)
      3'd0:       return PW_LONG;
      3'd1, 3'd2: return PW_SHORT;
      default:    return PW_NONE;
    endcase
  endfunction

endpackage

FILE: src/clpws_stream_if.sv
interface clpws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, input ready, output data);
  modport sink (input valid, output ready, input data);
endinterface

FILE: src/clpws_cfg_regs.sv
module clpws_cfg_regs import clpws_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [CfgW-1:0]    data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.instr_setup <= InstrSetupRst;
      cfg_q.char_setup  <= CharSetupRst;
      cfg_q.enable      <= EnableRst;
      cfg_q.long_wait   <= LongWaitRst;
      cfg_q.short_wait  <= ShortWaitRst;
    end else if (we_i) begin
      case (idx_i)
        REG_INSTR_SETUP: cfg_q.instr_setup <= data_i;
        REG_CHAR_SETUP:  cfg_q.char_setup  <= data_i;
        REG_ENABLE:      cfg_q.enable      <= data_i;
        REG_LONG_WAIT:   cfg_q.long_wait   <= data_i;
        REG_SHORT_WAIT:  cfg_q.short_wait  <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/clpws_core.sv
module clpws_core import clpws_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  cmd_t cmd_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETUP,
    PH_ENABLE,
    PH_POST
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [2:0]             wake_step_q, wake_step_d;
  logic                   in_wake_q, in_wake_d;
  post_e                  post_q, post_d;
  logic [7:0]             bus_q, bus_d;
  logic                   sel_q, sel_d;
  logic                   en_q, en_d;

  logic            rej;
  logic            fin;
  logic            wr_go;
  logic [7:0]      wr_byte;
  logic            wr_data;
  post_e           wr_post;
  logic [CfgW-1:0] post_val;
  logic [2:0]      wake_next;

  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [CfgW-1:0] v);
    if ((v >> COUNT_WIDTH) != '0) return '1;
    else return COUNT_WIDTH'(v);
  endfunction

  assign wake_next = 3'(wake_step_q + 3'd1);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    wake_step_d = wake_step_q;
    in_wake_d   = in_wake_q;
    post_d      = post_q;
    bus_d       = bus_q;
    sel_d       = sel_q;
    en_d        = en_q;
    rej         = 1'b0;
    fin         = 1'b0;
    wr_go       = 1'b0;
    wr_byte     = bus_q;
    wr_data     = 1'b0;
    wr_post     = PW_NONE;
    post_val    = '0;

    if (step_i) begin
      if (cmd_i.command == CMD_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (cnt_q > COUNT_WIDTH'(1)) begin
            cnt_d = cnt_q - COUNT_WIDTH'(1);
          end else begin
            case (phase_q)
              PH_SETUP: begin
                en_d    = 1'b1;
                phase_d = PH_ENABLE;
                cnt_d   = sat_count(cfg_i.enable);
              end
              PH_ENABLE: begin
                en_d = 1'b0;
                if (post_q == PW_LONG) post_val = cfg_i.long_wait;
                else if (post_q == PW_SHORT) post_val = cfg_i.short_wait;
                if (post_val != '0) begin
                  phase_d = PH_POST;
                  cnt_d   = sat_count(post_val);
                end else begin
                  fin = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end else if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        wr_go = 1'b1;
        case (cmd_i.command)
          CMD_INSTR: wr_byte = cmd_i.data_byte;
          CMD_CHAR: begin
            wr_byte = cmd_i.data_byte;
            wr_data = 1'b1;
          end
          CMD_SLOW_CHAR: begin
            wr_byte = cmd_i.data_byte;
            wr_data = 1'b1;
            wr_post = PW_LONG;
          end
          CMD_CURSOR: begin
            wr_byte = LcdDdramBase + (cmd_i.line_select ? LcdLineStride : 8'h00)
                      + {2'b00, cmd_i.column};
          end
          CMD_CLEAR: wr_byte = LcdClear;
          CMD_HOME:  wr_byte = LcdHome;
          default: begin
            in_wake_d   = 1'b1;
            wake_step_d = '0;
            wr_byte     = wake_byte(3'd0);
            wr_post     = wake_post(3'd0);
          end
        endcase
      end
    end

    if (fin) begin
      if (in_wake_q && (wake_step_q < WakeLastStep)) begin
        wake_step_d = wake_next;
        wr_go       = 1'b1;
        wr_byte     = wake_byte(wake_next);
        wr_post     = wake_post(wake_next);
      end else begin
        in_wake_d   = 1'b0;
        wake_step_d = '0;
        post_d      = PW_NONE;
        phase_d     = PH_IDLE;
        cnt_d       = '0;
      end
    end

    if (wr_go) begin
      bus_d   = wr_byte;
      sel_d   = wr_data;
      en_d    = 1'b0;
      post_d  = wr_post;
      phase_d = PH_SETUP;
      cnt_d   = sat_count(wr_data ? cfg_i.char_setup : cfg_i.instr_setup);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      wake_step_q <= '0;
      in_wake_q   <= 1'b0;
      post_q      <= PW_NONE;
      bus_q       <= '0;
      sel_q       <= 1'b0;
      en_q        <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      wake_step_q <= wake_step_d;
      in_wake_q   <= in_wake_d;
      post_q      <= post_d;
      bus_q       <= bus_d;
      sel_q       <= sel_d;
      en_q        <= en_d;
    end
  end

  always_comb begin
    res_o.bus_data   = bus_d;
    res_o.reg_sel    = sel_d;
    res_o.read_write = 1'b0;
    res_o.enable_pin = en_d;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.rejected   = rej;
  end

endmodule

FILE: src/clpws_out_fifo.sv
module clpws_out_fifo import clpws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  res_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      count_q <= 2'(count_q + {1'b0, push_i} - {1'b0, pop});
    end
  end

endmodule

FILE: src/char_lcd_parallel_write_sequencer_unit.sv
// Character LCD 8-bit parallel write sequencer. Each input item is a tick or a
// request (instruction, character, slow character, cursor move, clear, home,
// wake-up); every item yields exactly one result item showing the bus, register
// select, write level, enable level, busy flag and a rejected flag for a request
// that arrived while busy. Only tick items advance the setup, enable and post
// delays, counted in COUNT_WIDTH-bit counters that saturate on load. An item is
// taken every clock while the result queue has room: the whole state update is
// combinational from the state registers into a two-entry result queue, and
// ready falls only while it holds two results. The user must write the delay
// registers through the cfg port while the block is idle; it is not enforced.
module char_lcd_parallel_write_sequencer_unit import clpws_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  clpws_stream_if.sink       cmd_i,
  clpws_stream_if.source     res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t cfg;
  res_t res;
  res_t fifo_data;
  logic accept;
  logic space;

  assign accept      = cmd_i.valid && space;
  assign cmd_i.ready = space;

  clpws_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  clpws_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cmd_i  (cmd_i.data),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  clpws_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .data_o      (fifo_data)
  );

  assign res_o.data = fifo_data;

endmodule

FILE: src/clpws_checker.sv
`include "char_lcd_parallel_write_sequencer_unit_macros.svh"

module clpws_checker import clpws_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input res_t res_i
);

  `CLPWS_ASSERT_SAME(a_reject_while_busy, res_valid_i && res_i.rejected, res_i.busy_res, "rejected item shown with busy low")
  `CLPWS_ASSERT_SAME(a_enable_only_busy, res_valid_i && res_i.enable_pin, res_i.busy_res, "enable high while idle")
  `CLPWS_ASSERT_NEXT(a_result_holds, res_valid_i && !res_ready_i, res_valid_i && $stable(res_i), "stalled result changed")

endmodule

bind char_lcd_parallel_write_sequencer_unit clpws_checker u_clpws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.data)
);
